### rtl/bra_pkg.sv
package bra_pkg;

    localparam int MAP_BITS_DEF = 1024;
    localparam int WORD_BITS    = 32;
    localparam int WSEL_W       = 5;
    localparam int CNT_W        = 11;
    localparam int IDX_W        = 21;
    localparam int BASE_W       = 20;
    localparam int BYTES_W      = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int BYTES_RST    = 128;

    localparam logic [1:0] OP_TEST  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;

    typedef struct packed {
        logic              hit;
        logic [WSEL_W-1:0] idx;
    } t_scan_res;

endpackage

### rtl/bra_word_scan.sv
module bra_word_scan #(
    parameter int AW = 5,
    parameter int CW = 11
) (
    input  logic [bra_pkg::WORD_BITS-1:0] i_data,
    input  logic [AW-1:0]                 i_addr,
    input  logic [bra_pkg::CNT_W-1:0]     i_carry,
    input  logic [CW-1:0]                 i_used,
    input  logic [bra_pkg::CNT_W-1:0]     i_count,
    output bra_pkg::t_scan_res            o_res,
    output logic [bra_pkg::CNT_W-1:0]     o_carry
);
    import bra_pkg::*;

    localparam int PW = AW + WSEL_W;
    localparam int XW = (PW > CW) ? PW : CW;
    localparam int RW = CNT_W + 1;

    logic [WORD_BITS-1:0] free_v;
    logic [WORD_BITS-1:0] hit_v;
    logic [RW-1:0]        run_v [WORD_BITS];

    // free run ending at each bit: carry joins only if the word prefix is all free
    always_comb begin
        logic [WSEL_W:0] last;
        for (int j = 0; j < WORD_BITS; j++) begin
            free_v[j] = !i_data[j] &&
                        (XW'({i_addr, WSEL_W'(j)}) < XW'(i_used));
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            last = '0;
            for (int k = 0; k <= j; k++) begin
                if (!free_v[k]) begin
                    last = (WSEL_W + 1)'(k + 1);
                end
            end
            if (last == '0) begin
                run_v[j] = RW'(i_carry) + RW'(j + 1);
            end else begin
                run_v[j] = RW'(j + 1) - RW'(last);
            end
            hit_v[j] = run_v[j] >= RW'(i_count);
        end
    end

    always_comb begin
        o_res.hit = |hit_v;
        o_res.idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit_v[j]) begin
                o_res.idx = WSEL_W'(j);
            end
        end
        o_carry = run_v[WORD_BITS-1][CNT_W-1:0];
    end

endmodule

### rtl/bitmap_run_allocator.sv
// First-fit bitmap allocator, one occupancy bit per page, held in a
// 32-bit-wide synchronous RAM of ceil(MAP_BITS/32) words.
// Request channel (i_in_valid/o_in_ready): op, item_index, bit_value,
// run_length. Response channel (o_out_valid/i_out_ready): bit_read,
// run_start, status; exactly one response beat per request beat.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 is
// base_index, index 1 is bytes_in_use; write only while idle.
// Test and write read the RAM word, then modify/write it. An allocation
// scans the words in use one per cycle, then rewrites the words of the
// found run one per cycle; a miss answers once the last word in use has
// been scanned. Errors that need no RAM access answer straight from idle.
// One request is in flight at a time; the next is accepted while the
// previous response still waits in the output register. A stalled
// receiver holds the response and blocks completion of the next request.
// Reset clears the map by writing zero to every RAM word, during which
// no request is accepted; registers reset to base 0 and 128 bytes in use.
module bitmap_run_allocator #(
    parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [bra_pkg::IDX_W-1:0]    i_item_index,
    input  logic                         i_bit_value,
    input  logic [bra_pkg::CNT_W-1:0]    i_run_length,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_bit_read,
    output logic [bra_pkg::IDX_W-1:0]    o_run_start,
    output logic [1:0]                   o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bra_pkg::BASE_W-1:0]   i_cfg_data
);
    import bra_pkg::*;

    localparam int WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = AW + WSEL_W;
    localparam int CW    = $clog2(MAP_BITS + 1);
    localparam int NW    = (CW > CNT_W) ? CW : CNT_W;
    localparam int QW    = (PW > CNT_W) ? PW + 1 : CNT_W + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_TW    = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [AW-1:0]        mem_ra;
    logic [WORD_BITS-1:0] mem_wd;

    logic [2:0]           r_state, n_state;
    logic [AW:0]          r_ra, n_ra;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_pend_addr, n_pend_addr;
    logic [CNT_W-1:0]     r_carry, n_carry;
    logic [1:0]           r_op, n_op;
    logic                 r_val, n_val;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WSEL_W-1:0]    r_bitsel, n_bitsel;
    logic [AW-1:0]        r_waddr, n_waddr;
    logic [PW-1:0]        r_pos, n_pos;
    logic [PW-1:0]        r_end, n_end;
    logic                 r_res_bit, n_res_bit;
    logic [IDX_W-1:0]     r_res_start, n_res_start;
    logic [1:0]           r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_bit, n_out_bit;
    logic [IDX_W-1:0]     r_out_start, n_out_start;
    logic [1:0]           r_out_status, n_out_status;
    logic [BASE_W-1:0]    r_base;
    logic [BYTES_W-1:0]   r_bytes;

    logic [NW-1:0]        bytes_bits;
    logic [CW-1:0]        used_bits;
    logic [CW:0]          used_round;
    logic [AW:0]          words_used;
    logic [IDX_W-1:0]     rel_idx;
    logic                 idx_bad;
    logic [QW-1:0]        hit_pos;
    logic [WORD_BITS-1:0] fill_mask;
    logic [WORD_BITS-1:0] tw_word;
    t_scan_res            scan_res;
    logic [CNT_W-1:0]     scan_carry;

    bra_word_scan #(
        .AW (AW),
        .CW (CW)
    ) u_scan (
        .i_data  (r_rdata),
        .i_addr  (r_pend_addr),
        .i_carry (r_carry),
        .i_used  (used_bits),
        .i_count (r_cnt),
        .o_res   (scan_res),
        .o_carry (scan_carry)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_comb begin
        bytes_bits = NW'({r_bytes, 3'b000});
        if (bytes_bits > NW'(MAP_BITS)) begin
            used_bits = CW'(MAP_BITS);
        end else begin
            used_bits = bytes_bits[CW-1:0];
        end
        used_round = (CW + 1)'(used_bits) + (CW + 1)'(WORD_BITS - 1);
        words_used = (AW + 1)'(used_round >> WSEL_W);
        rel_idx    = i_item_index - IDX_W'(r_base);
        idx_bad    = (i_item_index < IDX_W'(r_base)) || (rel_idx >= IDX_W'(used_bits));
        hit_pos    = QW'({r_pend_addr, scan_res.idx}) + QW'(1) - QW'(r_cnt);
        for (int j = 0; j < WORD_BITS; j++) begin
            fill_mask[j] = ({r_pend_addr, WSEL_W'(j)} >= r_pos) &&
                           ({r_pend_addr, WSEL_W'(j)} <= r_end);
        end
        tw_word           = r_rdata;
        tw_word[r_bitsel] = r_val;
    end

    always_comb begin
        n_state      = r_state;
        n_ra         = r_ra;
        n_pend       = r_pend;
        n_pend_addr  = r_pend_addr;
        n_carry      = r_carry;
        n_op         = r_op;
        n_val        = r_val;
        n_cnt        = r_cnt;
        n_bitsel     = r_bitsel;
        n_waddr      = r_waddr;
        n_pos        = r_pos;
        n_end        = r_end;
        n_res_bit    = r_res_bit;
        n_res_start  = r_res_start;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_bit    = r_out_bit;
        n_out_start  = r_out_start;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_wa       = r_pend_addr;
        mem_wd       = r_rdata | fill_mask;
        mem_ra       = r_ra[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_ra[AW-1:0];
                mem_wd = '0;
                n_ra   = r_ra + 1'b1;
                if (r_ra == (AW + 1)'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_op         = i_op;
                n_val        = i_bit_value;
                n_cnt        = i_run_length;
                n_bitsel     = rel_idx[WSEL_W-1:0];
                n_waddr      = rel_idx[PW-1:WSEL_W];
                mem_ra       = rel_idx[PW-1:WSEL_W];
                n_res_bit    = 1'b0;
                n_res_start  = '0;
                n_res_status = ST_OK;
                n_ra         = '0;
                n_pend       = 1'b0;
                n_carry      = '0;
                if (i_in_valid) begin
                    case (i_op)
                        OP_TEST, OP_WRITE: begin
                            if (idx_bad) begin
                                n_res_status = ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_TW;
                            end
                        end
                        OP_ALLOC: begin
                            if (i_run_length == '0) begin
                                n_res_status = ST_RANGE;
                                n_state      = S_DONE;
                            end else if (used_bits == '0) begin
                                n_res_status = ST_NONE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_res_status = ST_RANGE;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_TW: begin
                if (r_op == OP_TEST) begin
                    n_res_bit = r_rdata[r_bitsel];
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_waddr;
                    mem_wd = tw_word;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (r_ra < words_used) begin
                    n_ra        = r_ra + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_ra[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_carry = scan_carry;
                    if (scan_res.hit) begin
                        n_pos   = hit_pos[PW-1:0];
                        n_end   = PW'(hit_pos + QW'(r_cnt) - QW'(1));
                        n_ra    = (AW + 1)'(hit_pos[PW-1:WSEL_W]);
                        n_pend  = 1'b0;
                        n_state = S_FILL;
                    end else if ((AW + 1)'(r_pend_addr) + 1'b1 == words_used) begin
                        n_res_status = ST_NONE;
                        n_pend       = 1'b0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_FILL: begin
                if (r_ra <= (AW + 1)'(r_end[PW-1:WSEL_W])) begin
                    n_ra        = r_ra + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_ra[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                    if (r_pend_addr == r_end[PW-1:WSEL_W]) begin
                        n_res_start = IDX_W'(r_base) + IDX_W'(r_pos);
                        n_pend      = 1'b0;
                        n_state     = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_bit    = r_res_bit;
                    n_out_start  = r_res_start;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ra        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_bytes     <= BYTES_W'(BYTES_RST);
        end else begin
            r_state     <= n_state;
            r_ra        <= n_ra;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE:  r_base  <= i_cfg_data;
                    CFG_BYTES: r_bytes <= i_cfg_data[BYTES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr  <= n_pend_addr;
        r_carry      <= n_carry;
        r_op         <= n_op;
        r_val        <= n_val;
        r_cnt        <= n_cnt;
        r_bitsel     <= n_bitsel;
        r_waddr      <= n_waddr;
        r_pos        <= n_pos;
        r_end        <= n_end;
        r_res_bit    <= n_res_bit;
        r_res_start  <= n_res_start;
        r_res_status <= n_res_status;
        r_out_bit    <= n_out_bit;
        r_out_start  <= n_out_start;
        r_out_status <= n_out_status;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_bit_read  = r_out_bit;
    assign o_run_start = r_out_start;
    assign o_status    = r_out_status;
    assign o_cfg_ready = 1'b1;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bra_pkg::*;

    localparam int MAP_BITS    = MAP_BITS_DEF;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 92;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] index;
        logic             value;
        logic [CNT_W-1:0] count;
    } t_page_req;

    typedef struct packed {
        logic             bit_read;
        logic [IDX_W-1:0] run_start;
        logic [1:0]       status;
    } t_page_resp;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_op;
    logic [IDX_W-1:0]     i_item_index;
    logic                 i_bit_value;
    logic [CNT_W-1:0]     i_run_length;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_bit_read;
    logic [IDX_W-1:0]     o_run_start;
    logic [1:0]           o_status;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BASE_W-1:0]    i_cfg_data;

    bitmap_run_allocator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_item_index (i_item_index),
        .i_bit_value  (i_bit_value),
        .i_run_length (i_run_length),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_bit_read   (o_bit_read),
        .o_run_start  (o_run_start),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    t_page_req          req_backlog[$];
    t_page_resp         due_replies[$];
    t_page_req          next_req;
    t_page_req          taken_req;
    t_page_resp         want;
    bit                 occ_map [MAP_BITS];
    logic [BASE_W-1:0]  cur_base;
    logic [BYTES_W-1:0] cur_bytes;
    bit                 req_taken = 1'b0;
    int                 n_queued = 0;
    int                 n_checked = 0;
    int                 n_errors = 0;
    int                 idle_cycles = 0;
    int                 req_gap = 0;
    int                 resp_stall = 0;
    int                 gap_top = 19;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int map_span();
        int n;
        n = 8 * int'(cur_bytes);
        return (n > MAP_BITS) ? MAP_BITS : n;
    endfunction

    // page map update and reply for one request
    function automatic t_page_resp apply_request(t_page_req r);
        t_page_resp res;
        int span, rel, run, first, i;
        res = '0;
        span = map_span();
        rel = int'(r.index) - int'(cur_base);
        first = -1;
        run = 0;
        case (r.op)
            OP_TEST, OP_WRITE: begin
                if (rel < 0 || rel >= span) begin
                    res.status = ST_RANGE;
                end else if (r.op == OP_TEST) begin
                    res.bit_read = occ_map[rel];
                end else begin
                    occ_map[rel] = r.value;
                end
            end
            OP_ALLOC: begin
                if (r.count == 0) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = 0; i < span && first < 0; i++) begin
                        run = occ_map[i] ? 0 : run + 1;
                        if (run == int'(r.count))
                            first = i + 1 - run;
                    end
                    if (first < 0) begin
                        res.status = ST_NONE;
                    end else begin
                        for (i = first; i < first + int'(r.count); i++)
                            occ_map[i] = 1'b1;
                        res.run_start = IDX_W'(int'(cur_base) + first);
                    end
                end
            end
            default: begin
                res.status = ST_RANGE;
            end
        endcase
        return res;
    endfunction

    task automatic queue_req(logic [1:0] op, logic [IDX_W-1:0] index, logic value,
                             logic [CNT_W-1:0] count);
        t_page_req r;
        r.op = op;
        r.index = index;
        r.value = value;
        r.count = count;
        req_backlog.push_back(r);
        n_queued++;
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [BASE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_BASE)
            cur_base = data;
        else if (idx == CFG_BYTES)
            cur_bytes = data[BYTES_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (n_checked != n_queued)
            @(negedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !req_taken) begin
            // beat still pending
        end else if (req_gap > 0) begin
            i_in_valid <= 1'b0;
            req_gap = req_gap - 1;
        end else if (req_backlog.size() > 0) begin
            next_req = req_backlog.pop_front();
            i_in_valid <= 1'b1;
            i_op <= next_req.op;
            i_item_index <= next_req.index;
            i_bit_value <= next_req.value;
            i_run_length <= next_req.count;
            req_gap = $urandom_range(gap_top, 0);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        req_taken <= i_in_valid && o_in_ready;
        if (i_in_valid && o_in_ready) begin
            taken_req.op = i_op;
            taken_req.index = i_item_index;
            taken_req.value = i_bit_value;
            taken_req.count = i_run_length;
            due_replies.push_back(apply_request(taken_req));
        end
    end

    // reply side
    always @(negedge i_clk) begin
        if (resp_stall > 0) begin
            i_out_ready <= 1'b0;
            resp_stall = resp_stall - 1;
        end else begin
            i_out_ready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_replies.size() == 0) begin
                $error("reply beat with no request outstanding");
                n_errors++;
            end else begin
                want = due_replies.pop_front();
                if (o_bit_read !== want.bit_read) begin
                    $error("bit_read: expected %0d, got %0d", want.bit_read, o_bit_read);
                    n_errors++;
                end
                if (o_run_start !== want.run_start) begin
                    $error("run_start: expected %0d, got %0d", want.run_start, o_run_start);
                    n_errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_errors++;
                end
            end
            n_checked++;
            if (n_checked == 300 || n_checked == 900)
                resp_stall = HOLD_CYCLES;
            else
                resp_stall = $urandom_range(((n_checked / 150) % 3 == 2) ? 0 : 19, 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL bitmap_run_allocator");
            $finish;
        end
    end

    initial begin
        int ph, k, sel, span, pos, burst;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   cnt;
        logic [BASE_W-1:0]  base_w;
        logic [BYTES_W-1:0] bytes_w;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_TEST;
        i_item_index = '0;
        i_bit_value = 1'b0;
        i_run_length = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data = '0;
        cur_base = '0;
        cur_bytes = BYTES_W'(BYTES_RST);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // whole map, edges, errors
        queue_req(OP_ALLOC, 0, 1'b0, 11'd1024);
        queue_req(OP_TEST, 0, 1'b0, 0);
        queue_req(OP_TEST, 1023, 1'b0, 0);
        queue_req(OP_WRITE, 0, 1'b0, 0);
        queue_req(OP_WRITE, 1023, 1'b0, 0);
        queue_req(OP_TEST, 0, 1'b1, 0);
        queue_req(OP_TEST, 1024, 1'b0, 0);
        queue_req(OP_WRITE, 21'h1FFFFF, 1'b1, 0);
        queue_req(OP_ALLOC, 0, 1'b0, 0);
        queue_req(OP_ALLOC, 0, 1'b0, 1);
        queue_req(OP_ALLOC, 0, 1'b0, 1);
        queue_req(OP_ALLOC, 0, 1'b0, 1);
        queue_req(OP_ALLOC, 0, 1'b0, 11'h7FF);
        queue_req(OP_SPARE, 5, 1'b1, 3);
        queue_req(OP_WRITE, 500, 1'b0, 0);
        queue_req(OP_WRITE, 501, 1'b0, 0);
        queue_req(OP_WRITE, 502, 1'b0, 0);
        queue_req(OP_ALLOC, 0, 1'b0, 2);
        queue_req(OP_TEST, 502, 1'b0, 0);
        queue_req(OP_WRITE, 502, 1'b1, 0);
        queue_req(OP_TEST, 502, 1'b0, 0);

        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin base_w = '0; bytes_w = 8'd1; end
                1: begin base_w = 20'hFFFFF; bytes_w = 8'd4; end
                2: begin base_w = $urandom; bytes_w = 8'd0; end
                3: begin base_w = 20'h00010; bytes_w = 8'd128; end
                4: begin base_w = $urandom; bytes_w = 8'd255; end
                5: begin base_w = 20'hFFFFF; bytes_w = 8'd128; end
                6: begin base_w = $urandom; bytes_w = 8'd2; end
                7: begin base_w = '0; bytes_w = 8'd16; end
                8: begin base_w = $urandom; bytes_w = $urandom_range(255, 1); end
                9: begin base_w = $urandom; bytes_w = 8'd8; end
                10: begin base_w = $urandom; bytes_w = 8'd3; end
                default: begin base_w = $urandom_range(7, 0); bytes_w = 8'd64; end
            endcase
            set_reg(CFG_BASE, base_w);
            set_reg(CFG_BYTES, {{(BASE_W-BYTES_W){1'b0}}, bytes_w});
            if (ph == 9)
                set_reg(CFG_SPARE, $urandom);
            gap_top = ph[0] ? 0 : 19;
            span = map_span();
            for (k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(99, 0);
                pos = int'($urandom_range(span + 7, 0)) - 4;
                idx = cur_base + pos;
                if ($urandom_range(19, 0) == 0)
                    idx = $urandom;
                cnt = $urandom;
                if (sel < 30) begin
                    case ($urandom_range(19, 0))
                        0: cnt = 0;
                        1: cnt = $urandom;
                        2, 3: cnt = $urandom_range(span + 2, 1);
                        default: cnt = $urandom_range(8, 1);
                    endcase
                    queue_req(OP_ALLOC, idx, $urandom, cnt);
                end else if (sel < 62) begin
                    queue_req(OP_WRITE, idx, $urandom_range(3, 0) == 0, cnt);
                end else if (sel < 92) begin
                    queue_req(OP_TEST, idx, $urandom, cnt);
                end else if (sel < 96) begin
                    queue_req(OP_SPARE, idx, $urandom, cnt);
                end else begin
                    // free a stretch of pages
                    pos = $urandom_range(span, 0);
                    for (burst = $urandom_range(16, 1); burst > 0; burst--) begin
                        queue_req(OP_WRITE, cur_base + pos, 1'b0, cnt);
                        pos++;
                    end
                end
            end
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (due_replies.size() != 0) begin
            $error("%0d replies never arrived", due_replies.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("PASS bitmap_run_allocator");
        else
            $display("FAIL bitmap_run_allocator");
        $finish;
    end

endmodule

### bitmap_run_allocator.f
rtl/bra_pkg.sv
rtl/bra_word_scan.sv
rtl/bitmap_run_allocator.sv
tb/testbench.sv
